### sv/met_pkg.sv
// ----------------------------------------------------------------------------
// met_pkg
// Shared types and constants of the Mandelbrot escape-time unit.
// ----------------------------------------------------------------------------
package met_pkg;

    // Fixed field widths
    localparam int PIX_W      = 12;
    localparam int DIM_W      = 13;
    localparam int LIMIT_W    = 16;
    localparam int STEP_W     = 32;
    localparam int ITER_OUT_W = 16;
    localparam int HUE_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Largest image dimension honored; larger values are clamped
    localparam int MAX_DIM = 4096;

    // Number of iteration cells in the ring
    localparam int N_CELLS = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_IM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_RE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_IM = 3'd6;

    // Register reset values
    localparam logic [LIMIT_W-1:0]       RST_MAX_ITER  = 16'd256;
    localparam logic [DIM_W-1:0]         RST_WIDTH     = 13'd400;
    localparam logic [DIM_W-1:0]         RST_HEIGHT    = 13'd600;
    localparam logic signed [STEP_W-1:0] RST_STEP_RE   = 32'sd503316;
    localparam logic signed [STEP_W-1:0] RST_STEP_IM   = 32'sd223696;
    localparam logic signed [STEP_W-1:0] RST_CENTER_RE = 32'sd0;
    localparam logic signed [STEP_W-1:0] RST_CENTER_IM = 32'sd0;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAP,
        ST_RUN,
        ST_FINISH
    } t_met_state;

    // Completion status reported by one cell
    typedef struct packed {
        logic done;
        logic escaped;
    } t_met_flags;

endpackage

### sv/met_map.sv
// ----------------------------------------------------------------------------
// met_map
// Maps a pixel position to the complex point c in three registered steps:
// center offset, step multiply, center add with saturation.
// ----------------------------------------------------------------------------
module met_map #(
    parameter int FRAC_BITS = 26
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic [met_pkg::PIX_W-1:0]              i_pixel_x,
    input  logic [met_pkg::PIX_W-1:0]              i_pixel_y,
    input  logic [met_pkg::DIM_W-1:0]              i_width,
    input  logic [met_pkg::DIM_W-1:0]              i_height,
    input  logic signed [met_pkg::STEP_W-1:0]      i_step_re,
    input  logic signed [met_pkg::STEP_W-1:0]      i_step_im,
    input  logic signed [met_pkg::STEP_W-1:0]      i_center_re,
    input  logic signed [met_pkg::STEP_W-1:0]      i_center_im,
    output logic                                   o_valid,
    output logic signed [FRAC_BITS+5:0]            o_c_re,
    output logic signed [FRAC_BITS+5:0]            o_c_im
);
    import met_pkg::*;

    localparam int CW     = FRAC_BITS + 6;
    localparam int DX_W   = PIX_W + 1;
    localparam int PROD_W = DX_W + STEP_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int MW     = (SUM_W > CW) ? SUM_W : CW;
    localparam logic [31:0] MAX_DIM_V = 32'(MAX_DIM);
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    logic [DIM_W-1:0]          w_w_cl;
    logic [DIM_W-1:0]          w_h_cl;
    logic signed [DX_W-1:0]    n_dx;
    logic signed [DX_W-1:0]    n_dy;
    logic signed [DX_W-1:0]    r_dx;
    logic signed [DX_W-1:0]    r_dy;
    logic signed [PROD_W-1:0]  r_prod_re;
    logic signed [PROD_W-1:0]  r_prod_im;
    logic signed [MW-1:0]      w_sum_re;
    logic signed [MW-1:0]      w_sum_im;
    logic signed [CW-1:0]      n_c_re;
    logic signed [CW-1:0]      n_c_im;
    logic signed [CW-1:0]      r_c_re;
    logic signed [CW-1:0]      r_c_im;
    logic                      r_va;
    logic                      r_vb;
    logic                      r_vc;

    // Clamp dimensions, signed offset from the integer half
    always_comb begin
        w_w_cl = ({19'b0, i_width} > MAX_DIM_V) ? MAX_DIM_V[DIM_W-1:0] : i_width;
        w_h_cl = ({19'b0, i_height} > MAX_DIM_V) ? MAX_DIM_V[DIM_W-1:0] : i_height;
        n_dx   = $signed({1'b0, i_pixel_x}) - $signed({1'b0, w_w_cl[DIM_W-1:1]});
        n_dy   = $signed({1'b0, i_pixel_y}) - $signed({1'b0, w_h_cl[DIM_W-1:1]});
    end

    // Center add and saturation to the component range
    always_comb begin
        w_sum_re = MW'(r_prod_re) + MW'(i_center_re);
        w_sum_im = MW'(r_prod_im) + MW'(i_center_im);
        if ((&w_sum_re[MW-1:CW-1]) || !(|w_sum_re[MW-1:CW-1])) begin
            n_c_re = w_sum_re[CW-1:0];
        end else begin
            n_c_re = w_sum_re[MW-1] ? C_MIN : C_MAX;
        end
        if ((&w_sum_im[MW-1:CW-1]) || !(|w_sum_im[MW-1:CW-1])) begin
            n_c_im = w_sum_im[CW-1:0];
        end else begin
            n_c_im = w_sum_im[MW-1] ? C_MIN : C_MAX;
        end
    end

    // Valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    // Data pipe
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
        if (r_va) begin
            r_prod_re <= r_dx * i_step_re;
            r_prod_im <= r_dy * i_step_im;
        end
        if (r_vb) begin
            r_c_re <= n_c_re;
            r_c_im <= n_c_im;
        end
    end

    assign o_valid = r_vc;
    assign o_c_re  = r_c_re;
    assign o_c_im  = r_c_im;

endmodule

### sv/met_cell.sv
// ----------------------------------------------------------------------------
// met_cell
// One ring cell: a single z = z*z + c iteration over two register stages.
// Stage 0 holds z and forms the three magnitude products; stage 1 runs the
// escape test on z and produces the next z for the neighbor cell.
// ----------------------------------------------------------------------------
module met_cell #(
    parameter int FRAC_BITS = 26,
    parameter int ITER_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ITER_BITS-1:0]          i_limit,
    input  logic signed [FRAC_BITS+5:0]   i_c_re,
    input  logic signed [FRAC_BITS+5:0]   i_c_im,
    input  logic                          i_valid,
    input  logic signed [FRAC_BITS+5:0]   i_re,
    input  logic signed [FRAC_BITS+5:0]   i_im,
    input  logic [ITER_BITS-1:0]          i_count,
    output logic                          o_valid,
    output logic signed [FRAC_BITS+5:0]   o_re,
    output logic signed [FRAC_BITS+5:0]   o_im,
    output logic [ITER_BITS-1:0]          o_count,
    output met_pkg::t_met_flags           o_flags,
    output logic [ITER_BITS-1:0]          o_res_count
);
    import met_pkg::*;

    localparam int CW = FRAC_BITS + 6;
    localparam int TW = 2 * CW - FRAC_BITS;
    localparam int SW = TW + 2;
    localparam logic [2*CW:0] ESC_LIM = (2 * CW + 1)'(1) << (2 * FRAC_BITS + 2);
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    logic                    r_v0;
    logic signed [CW-1:0]    r_re;
    logic signed [CW-1:0]    r_im;
    logic [ITER_BITS-1:0]    r_k0;
    logic [CW-1:0]           w_mre;
    logic [CW-1:0]           w_mim;
    logic                    r_v1;
    logic [2*CW-1:0]         r_sq_re;
    logic [2*CW-1:0]         r_sq_im;
    logic [2*CW-1:0]         r_prod;
    logic                    r_neg;
    logic [ITER_BITS-1:0]    r_k1;
    logic [2*CW:0]           w_mag2;
    logic                    w_esc;
    logic                    w_at_lim;
    logic signed [SW-1:0]    w_nre;
    logic signed [SW-1:0]    w_cross;
    logic signed [SW-1:0]    w_nim;

    // Operand magnitudes
    always_comb begin
        w_mre = r_re[CW-1] ? CW'(~r_re + 1'b1) : r_re;
        w_mim = r_im[CW-1] ? CW'(~r_im + 1'b1) : r_im;
    end

    // Stage 0: z from the neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_re <= i_re;
            r_im <= i_im;
            r_k0 <= i_count;
        end
        if (r_v0) begin
            r_sq_re <= w_mre * w_mre;
            r_sq_im <= w_mim * w_mim;
            r_prod  <= w_mre * w_mim;
            r_neg   <= r_re[CW-1] ^ r_im[CW-1];
            r_k1    <= r_k0;
        end
    end

    // Stage 1: escape test on z (exact), next z from truncated products
    always_comb begin
        w_mag2   = {1'b0, r_sq_re} + {1'b0, r_sq_im};
        w_esc    = w_mag2 > ESC_LIM;
        w_at_lim = r_k1 == i_limit;
        w_nre    = $signed({2'b00, r_sq_re[2*CW-1:FRAC_BITS]})
                 - $signed({2'b00, r_sq_im[2*CW-1:FRAC_BITS]})
                 + SW'(i_c_re);
        w_cross  = $signed({1'b0, r_prod[2*CW-1:FRAC_BITS], 1'b0});
        w_nim    = (r_neg ? -w_cross : w_cross) + SW'(i_c_im);
    end

    // Saturation of the next z
    always_comb begin
        if ((&w_nre[SW-1:CW-1]) || !(|w_nre[SW-1:CW-1])) begin
            o_re = w_nre[CW-1:0];
        end else begin
            o_re = w_nre[SW-1] ? C_MIN : C_MAX;
        end
        if ((&w_nim[SW-1:CW-1]) || !(|w_nim[SW-1:CW-1])) begin
            o_im = w_nim[CW-1:0];
        end else begin
            o_im = w_nim[SW-1] ? C_MIN : C_MAX;
        end
    end

    // Hand-off or completion
    always_comb begin
        o_valid         = r_v1 && !w_esc && !w_at_lim;
        o_count         = ITER_BITS'(r_k1 + 1'b1);
        o_flags.done    = r_v1 && (w_esc || w_at_lim);
        o_flags.escaped = r_v1 && w_esc;
        o_res_count     = w_esc ? ITER_BITS'(r_k1 - 1'b1) : r_k1;
    end

endmodule

### sv/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time iteration for one pixel at a time. The pixel is mapped to c,
// then z = z*z + c circulates through a ring of iteration cells; each
// iteration passes through the operand register and the product register
// of a cell. One result item follows each pixel item in order. The output
// register lets the next pixel be taken while a result waits for the
// consumer.
// Configuration writes are accepted every cycle and must only be issued while
// the unit is idle.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time #(
    parameter int FRAC_BITS = 26,
    parameter int ITER_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // pixel items
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [met_pkg::PIX_W-1:0]         i_pixel_x,
    input  logic [met_pkg::PIX_W-1:0]         i_pixel_y,
    // result items
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [met_pkg::ITER_OUT_W-1:0]    o_iterations,
    output logic                              o_escaped,
    output logic [met_pkg::HUE_W-1:0]         o_hue,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [met_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [met_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import met_pkg::*;

    localparam int CW = FRAC_BITS + 6;

    logic [LIMIT_W-1:0]        r_max_iter;
    logic [DIM_W-1:0]          r_width;
    logic [DIM_W-1:0]          r_height;
    logic signed [STEP_W-1:0]  r_step_re;
    logic signed [STEP_W-1:0]  r_step_im;
    logic signed [STEP_W-1:0]  r_center_re;
    logic signed [STEP_W-1:0]  r_center_im;

    t_met_state                r_state;
    t_met_state                n_state;
    logic                      w_accept;
    logic                      w_launch;
    logic                      w_hold_load;
    logic                      w_out_load;

    logic                      w_map_valid;
    logic signed [CW-1:0]      w_c_re;
    logic signed [CW-1:0]      w_c_im;
    logic [ITER_BITS-1:0]      w_limit;

    logic                      w_in_valid [N_CELLS];
    logic signed [CW-1:0]      w_in_re    [N_CELLS];
    logic signed [CW-1:0]      w_in_im    [N_CELLS];
    logic [ITER_BITS-1:0]      w_in_cnt   [N_CELLS];
    logic                      w_out_vld  [N_CELLS];
    logic signed [CW-1:0]      w_out_re   [N_CELLS];
    logic signed [CW-1:0]      w_out_im   [N_CELLS];
    logic [ITER_BITS-1:0]      w_out_cnt  [N_CELLS];
    t_met_flags                w_flags    [N_CELLS];
    logic [ITER_BITS-1:0]      w_res_cnt  [N_CELLS];

    logic                      w_ring_done;
    logic                      w_ring_esc;
    logic [ITER_BITS-1:0]      w_ring_cnt;

    logic [ITER_BITS-1:0]      r_hold_cnt;
    logic                      r_hold_esc;
    logic                      r_out_valid;
    logic [ITER_OUT_W-1:0]     r_out_iter;
    logic                      r_out_esc;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter  <= RST_MAX_ITER;
            r_width     <= RST_WIDTH;
            r_height    <= RST_HEIGHT;
            r_step_re   <= RST_STEP_RE;
            r_step_im   <= RST_STEP_IM;
            r_center_re <= RST_CENTER_RE;
            r_center_im <= RST_CENTER_IM;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                CFG_MAX_ITER:  r_max_iter  <= i_cfg_data[LIMIT_W-1:0];
                CFG_WIDTH:     r_width     <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT:    r_height    <= i_cfg_data[DIM_W-1:0];
                CFG_STEP_RE:   r_step_re   <= $signed(i_cfg_data);
                CFG_STEP_IM:   r_step_im   <= $signed(i_cfg_data);
                CFG_CENTER_RE: r_center_re <= $signed(i_cfg_data);
                CFG_CENTER_IM: r_center_im <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    assign w_limit = ITER_BITS'(r_max_iter);

    // Controller: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_MAP;
            ST_MAP:    if (w_map_valid) n_state = ST_RUN;
            ST_RUN:    if (w_ring_done) n_state = ST_FINISH;
            ST_FINISH: if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Controller: outputs
    always_comb begin
        o_in_stall  = 1'b1;
        w_launch    = 1'b0;
        w_hold_load = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE:   o_in_stall = 1'b0;
            ST_MAP:    w_launch = w_map_valid;
            ST_RUN:    w_hold_load = w_ring_done;
            ST_FINISH: w_out_load = !r_out_valid || !i_out_stall;
            default: begin
            end
        endcase
    end

    assign w_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Coordinate mapping
    met_map #(
        .FRAC_BITS (FRAC_BITS)
    ) u_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_accept),
        .i_pixel_x   (i_pixel_x),
        .i_pixel_y   (i_pixel_y),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_step_re   (r_step_re),
        .i_step_im   (r_step_im),
        .i_center_re (r_center_re),
        .i_center_im (r_center_im),
        .o_valid     (w_map_valid),
        .o_c_re      (w_c_re),
        .o_c_im      (w_c_im)
    );

    // Ring entry: a new pixel starts from z = 0, otherwise the last cell feeds back
    always_comb begin
        w_in_valid[0] = w_launch || w_out_vld[N_CELLS-1];
        w_in_re[0]    = w_launch ? '0 : w_out_re[N_CELLS-1];
        w_in_im[0]    = w_launch ? '0 : w_out_im[N_CELLS-1];
        w_in_cnt[0]   = w_launch ? '0 : w_out_cnt[N_CELLS-1];
    end

    // Ring of iteration cells
    for (genvar j = 0; j < N_CELLS; j++) begin : g_cell
        if (j > 0) begin : g_link
            assign w_in_valid[j] = w_out_vld[j-1];
            assign w_in_re[j]    = w_out_re[j-1];
            assign w_in_im[j]    = w_out_im[j-1];
            assign w_in_cnt[j]   = w_out_cnt[j-1];
        end

        met_cell #(
            .FRAC_BITS (FRAC_BITS),
            .ITER_BITS (ITER_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_limit     (w_limit),
            .i_c_re      (w_c_re),
            .i_c_im      (w_c_im),
            .i_valid     (w_in_valid[j]),
            .i_re        (w_in_re[j]),
            .i_im        (w_in_im[j]),
            .i_count     (w_in_cnt[j]),
            .o_valid     (w_out_vld[j]),
            .o_re        (w_out_re[j]),
            .o_im        (w_out_im[j]),
            .o_count     (w_out_cnt[j]),
            .o_flags     (w_flags[j]),
            .o_res_count (w_res_cnt[j])
        );
    end

    // Collect completion; at most one cell is active
    always_comb begin
        w_ring_done = 1'b0;
        w_ring_esc  = 1'b0;
        w_ring_cnt  = '0;
        for (int j = 0; j < N_CELLS; j++) begin
            w_ring_done = w_ring_done | w_flags[j].done;
            w_ring_esc  = w_ring_esc | w_flags[j].escaped;
            w_ring_cnt  = w_ring_cnt | (w_flags[j].done ? w_res_cnt[j] : '0);
        end
    end

    // Result hold and output register
    always_ff @(posedge i_clk) begin
        if (w_hold_load) begin
            r_hold_cnt <= w_ring_cnt;
            r_hold_esc <= w_ring_esc;
        end
        if (w_out_load) begin
            r_out_iter <= ITER_OUT_W'(r_hold_cnt);
            r_out_esc  <= r_hold_esc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_iterations = r_out_iter;
    assign o_escaped    = r_out_esc;
    assign o_hue        = r_out_iter[HUE_W-1:0];

endmodule

### sv/met_chk.sv
// ----------------------------------------------------------------------------
// met_chk
// Port-level checks of the escape-time unit, bound to the top level.
// ----------------------------------------------------------------------------
module met_chk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_stall,
    input  logic [met_pkg::PIX_W-1:0]         i_pixel_x,
    input  logic [met_pkg::PIX_W-1:0]         i_pixel_y,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  logic [met_pkg::ITER_OUT_W-1:0]    o_iterations,
    input  logic                              o_escaped,
    input  logic [met_pkg::HUE_W-1:0]         o_hue
);
    import met_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_iterations) && $stable(o_escaped))
        else $error("stalled result item changed");

    // A stalled pixel item holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=>
            i_in_valid && $stable(i_pixel_x) && $stable(i_pixel_y))
        else $error("stalled pixel item changed");

    // Hue is the low byte of the count
    a_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_hue == o_iterations[HUE_W-1:0])
        else $error("hue does not match iteration count");

    // One pixel in flight: an accepted item blocks the next
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item accepted while one is in flight");

    // Reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind mandelbrot_escape_time met_chk u_met_chk (.*);

### tb/sv/mandelbrot_escape_time_tb.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_tb
// Self-checking bench for the escape-time unit. Each pixel item that is sent
// is mapped and iterated by a behavioral predictor; the predicted count, flag
// and hue are queued and compared with every result item in order. Directed
// tests cover the reset view, the zero limit, dimension clamping, the escape
// radius boundary, saturation, the longest counts and a long receiver
// hold-off. Random views follow under several idle and stall mixes.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import met_pkg::*;

    localparam int     FRAC_BITS   = 26;
    localparam longint Q_ONE       = 64'sd1 <<< FRAC_BITS;
    localparam longint COMP_MAX    = (64'sd1 <<< (FRAC_BITS + 5)) - 1;
    localparam longint COMP_MIN    = -(64'sd1 <<< (FRAC_BITS + 5));
    localparam logic [64:0] RADIUS_SQ = 65'd1 << (2 * FRAC_BITS + 2);
    localparam int     CYCLE_LIMIT = 3_000_000;
    localparam int     END_WAIT    = 600;

    typedef struct {
        logic [ITER_OUT_W-1:0] iterations;
        logic                  escaped;
        logic [HUE_W-1:0]      hue;
    } t_escape_result;

    // DUT connections
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [PIX_W-1:0]      i_pixel_x   = '0;
    logic [PIX_W-1:0]      i_pixel_y   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [ITER_OUT_W-1:0] o_iterations;
    logic                  o_escaped;
    logic [HUE_W-1:0]      o_hue;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Register shadow used by the predictor
    logic [LIMIT_W-1:0]       cfg_max_iter  = RST_MAX_ITER;
    logic [DIM_W-1:0]         cfg_width     = RST_WIDTH;
    logic [DIM_W-1:0]         cfg_height    = RST_HEIGHT;
    logic signed [STEP_W-1:0] cfg_step_re   = RST_STEP_RE;
    logic signed [STEP_W-1:0] cfg_step_im   = RST_STEP_IM;
    logic signed [STEP_W-1:0] cfg_center_re = RST_CENTER_RE;
    logic signed [STEP_W-1:0] cfg_center_im = RST_CENTER_IM;

    t_escape_result pending_results[$];
    t_escape_result oldest_result;
    int             error_count  = 0;
    int             cycle_count  = 0;
    int             tx_idle_pct  = 0;
    int             rx_stall_pct = 0;
    logic           rx_hold      = 1'b0;

    // Idle mixes: none, sender idle, receiver stalling, both
    int tx_pct_by_mode[4] = '{0, 83, 0, 21};
    int rx_pct_by_mode[4] = '{0, 0, 83, 21};

    mandelbrot_escape_time #(
        .FRAC_BITS(FRAC_BITS),
        .ITER_BITS(16)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_pixel_x   (i_pixel_x),
        .i_pixel_y   (i_pixel_y),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_iterations(o_iterations),
        .o_escaped   (o_escaped),
        .o_hue       (o_hue),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint clamp_comp(input longint v);
        if (v > COMP_MAX) return COMP_MAX;
        if (v < COMP_MIN) return COMP_MIN;
        return v;
    endfunction

    // Full product, shifted down with truncation toward zero
    function automatic longint fix_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        if (p < 0) return -((-p) >>> FRAC_BITS);
        return p >>> FRAC_BITS;
    endfunction

    // Exact |z|^2 > 4
    function automatic logic beyond_radius(input longint a, input longint b);
        logic [64:0] mag2;
        mag2 = 65'(a * a) + 65'(b * b);
        return mag2 > RADIUS_SQ;
    endfunction

    function automatic t_escape_result predict_escape(input logic [PIX_W-1:0] px,
                                                      input logic [PIX_W-1:0] py);
        t_escape_result r;
        logic [DIM_W-1:0] w_eff;
        logic [DIM_W-1:0] h_eff;
        longint c_re, c_im, z_re, z_im, nxt_re;
        int unsigned n;
        w_eff = (cfg_width > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg_width;
        h_eff = (cfg_height > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg_height;
        // signed offset from the screen center, never rejected
        c_re = clamp_comp((longint'(px) - longint'(w_eff >> 1)) * longint'(cfg_step_re)
                          + longint'(cfg_center_re));
        c_im = clamp_comp((longint'(py) - longint'(h_eff >> 1)) * longint'(cfg_step_im)
                          + longint'(cfg_center_im));
        z_re = 0;
        z_im = 0;
        n = 0;
        r.escaped = 1'b0;
        while (n < cfg_max_iter) begin
            nxt_re = clamp_comp(fix_mul(z_re, z_re) - fix_mul(z_im, z_im) + c_re);
            z_im   = clamp_comp(2 * fix_mul(z_re, z_im) + c_im);
            z_re   = nxt_re;
            if (beyond_radius(z_re, z_im)) begin
                r.escaped = 1'b1;
                break;
            end
            n++;
        end
        r.iterations = n[ITER_OUT_W-1:0];
        r.hue        = n[HUE_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 100)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result item with nothing pending: iter %0d",
                                          o_iterations));
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_iterations !== oldest_result.iterations)
                    report_mismatch($sformatf("iterations %0d, predicted %0d",
                                              o_iterations, oldest_result.iterations));
                if (o_escaped !== oldest_result.escaped)
                    report_mismatch($sformatf("escaped %b, predicted %b",
                                              o_escaped, oldest_result.escaped));
                if (o_hue !== oldest_result.hue)
                    report_mismatch($sformatf("hue %0d, predicted %0d",
                                              o_hue, oldest_result.hue));
            end
        end
        i_out_stall <= rx_hold || ($urandom_range(0, 99) < rx_stall_pct);
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
        int gap;
        gap = 0;
        while (gap < 60 && $urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_x  <= px;
        i_pixel_y  <= py;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(predict_escape(px, py));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (addr)
            CFG_MAX_ITER:  cfg_max_iter  = data[LIMIT_W-1:0];
            CFG_WIDTH:     cfg_width     = data[DIM_W-1:0];
            CFG_HEIGHT:    cfg_height    = data[DIM_W-1:0];
            CFG_STEP_RE:   cfg_step_re   = data;
            CFG_STEP_IM:   cfg_step_im   = data;
            CFG_CENTER_RE: cfg_center_re = data;
            CFG_CENTER_IM: cfg_center_im = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Drain, then rewrite every register
    task automatic load_config(input logic [LIMIT_W-1:0] lim,
                               input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                               input logic [31:0] sre, input logic [31:0] sim,
                               input logic [31:0] cre, input logic [31:0] cim);
        wait_idle();
        write_reg(CFG_MAX_ITER, lim);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_STEP_RE, sre);
        write_reg(CFG_STEP_IM, sim);
        write_reg(CFG_CENTER_RE, cre);
        write_reg(CFG_CENTER_IM, cim);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers as they come out of reset
    task automatic test_reset_view();
        send_pixel(12'd200, 12'd300);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd399, 12'd599);
        send_pixel(12'd4095, 12'd4095);
    endtask

    task automatic test_zero_limit();
        load_config(16'd0, 13'd400, 13'd600, RST_STEP_RE, RST_STEP_IM, 32'd0, 32'd0);
        send_pixel(12'd200, 12'd300);
        send_pixel(12'd0, 12'd4095);
    endtask

    // Oversized dimensions clamp, tiny ones are used as given
    task automatic test_dimension_clamp();
        load_config(16'd32, 13'd8191, 13'd4097, 32'(Q_ONE >>> 10), 32'(Q_ONE >>> 11),
                    32'(-(Q_ONE >>> 1)), 32'd0);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd0, 12'd4095);
        load_config(16'd32, 13'd0, 13'd1, 32'(Q_ONE >>> 12), 32'(Q_ONE >>> 12),
                    32'(-(Q_ONE >>> 2)), 32'(Q_ONE >>> 3));
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd1);
    endtask

    // Points sitting exactly on |z|^2 = 4 do not escape on that iteration
    task automatic test_escape_boundary();
        load_config(16'd64, 13'd2, 13'd2, 32'd0, 32'd0, 32'(-2 * Q_ONE), 32'd0);
        send_pixel(12'd1, 12'd1);
        load_config(16'd64, 13'd2, 13'd2, 32'd0, 32'd0, 32'(2 * Q_ONE), 32'd0);
        send_pixel(12'd1, 12'd1);
        load_config(16'd64, 13'd2, 13'd2, 32'd0, 32'd0, 32'd0, 32'(2 * Q_ONE));
        send_pixel(12'd1, 12'd1);
        load_config(16'd64, 13'd2, 13'd2, 32'd0, 32'd0, 32'(Q_ONE >>> 2), 32'd0);
        send_pixel(12'd1, 12'd1);
    endtask

    // Extreme steps and centers drive c into saturation
    task automatic test_saturation();
        load_config(16'd16, 13'd4096, 13'd4096, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h8000_0000);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd2048, 12'd2048);
    endtask

    // Inside points at large limits: full count and hue wrap
    task automatic test_long_count();
        load_config(16'd65535, 13'd2, 13'd2, 32'd0, 32'd0, 32'd0, 32'd0);
        send_pixel(12'd1, 12'd1);
        load_config(16'd300, 13'd2, 13'd2, 32'd0, 32'd0, 32'(Q_ONE >>> 2), 32'd0);
        send_pixel(12'd1, 12'd1);
        send_pixel(12'd0, 12'd1);
    endtask

    // Receiver holds off long enough for the unit to back up into its input
    task automatic test_back_pressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        load_config(16'd16, 13'd64, 13'd64, 32'(Q_ONE >>> 4), 32'(Q_ONE >>> 5),
                    32'(-(Q_ONE >>> 1)), 32'd0);
        fork
            begin
                rx_hold <= 1'b1;
                repeat (800) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        for (int k = 0; k < 12; k++)
            send_pixel(12'($urandom_range(0, 63)), 12'($urandom_range(0, 63)));
        wait_idle();
    endtask

    // Random views, mostly well-formed pixels inside the image, some noise
    task automatic test_random_views();
        int unsigned w, h, zoom, lim, w_eff, h_eff;
        longint      sre, sim, cre, cim;
        bit          wild;
        logic [PIX_W-1:0] px, py;
        for (int ph = 0; ph < 8; ph++) begin
            wild = (ph == 6);
            if (wild) begin
                w   = $urandom_range(0, 8191);
                h   = $urandom_range(0, 8191);
                lim = $urandom_range(1, 1024);
                sre = longint'($signed($urandom()));
                sim = longint'($signed($urandom()));
                cre = longint'($signed($urandom()));
                cim = longint'($signed($urandom()));
            end else begin
                w    = $urandom_range(2, 4096);
                h    = $urandom_range(2, 4096);
                zoom = $urandom_range(1, 64);
                lim  = (ph == 3) ? 300 : $urandom_range(1, 64);
                sre  = (3 * Q_ONE) / longint'(w * zoom);
                sim  = (2 * Q_ONE) / longint'(h * zoom);
                // centers over the interesting region, re in [-1.5, 0.5]
                cre  = longint'($urandom_range(0, 2 * Q_ONE)) - (3 * Q_ONE) / 2;
                cim  = longint'($urandom_range(0, Q_ONE)) - Q_ONE / 2;
            end
            load_config(LIMIT_W'(lim), DIM_W'(w), DIM_W'(h), 32'(sre), 32'(sim),
                        32'(cre), 32'(cim));
            tx_idle_pct  = tx_pct_by_mode[ph % 4];
            rx_stall_pct = rx_pct_by_mode[ph % 4];
            w_eff = (w > MAX_DIM) ? MAX_DIM : w;
            h_eff = (h > MAX_DIM) ? MAX_DIM : h;
            for (int k = 0; k < 190; k++) begin
                if (wild || w_eff == 0 || $urandom_range(0, 9) == 0)
                    px = 12'($urandom_range(0, 4095));
                else
                    px = 12'($urandom_range(0, w_eff - 1));
                if (wild || h_eff == 0 || $urandom_range(0, 9) == 0)
                    py = 12'($urandom_range(0, 4095));
                else
                    py = 12'($urandom_range(0, h_eff - 1));
                send_pixel(px, py);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_view();
        test_zero_limit();
        test_dimension_clamp();
        test_escape_boundary();
        test_saturation();
        test_long_count();
        test_back_pressure();
        test_random_views();

        wait_idle();
        repeat (END_WAIT) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
